@@ rtl/nibble_handshake_link_core_defines.svh @@
// Assertion helpers for the link RTL
`ifndef NIBBLE_HANDSHAKE_LINK_CORE_DEFINES_SVH
`define NIBBLE_HANDSHAKE_LINK_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define NHL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nibble link check failed");

// next-cycle implication, held off during reset
`define NHL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nibble link check failed");

`endif

@@ rtl/nhl_pkg.sv @@
package nhl_pkg;

    localparam int PHASE_W = 4;
    localparam int MODE_W  = 2;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RX_LO    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RX_LOREL = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RX_HI    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_RX_HIREL = 4'd4;
    localparam logic [PHASE_W-1:0] PH_TX_READY = 4'd5;
    localparam logic [PHASE_W-1:0] PH_TX_LO    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TX_LOREL = 4'd7;
    localparam logic [PHASE_W-1:0] PH_TX_HI    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_TX_HIREL = 4'd9;
    localparam logic [PHASE_W-1:0] PH_TX_NEXT  = 4'd10;

    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    typedef struct packed {
        logic       panel_has_data_n;
        logic       panel_can_take_n;
        logic       confirm_n;
        logic [3:0] nibble_in;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
    } item_t;

    typedef struct packed {
        logic       select_n;
        logic       direction_pin;
        logic       half_pin;
        logic [3:0] nibble_out;
        logic       drive_enable;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_accept;
        logic       busy_res;
    } result_t;

endpackage

@@ rtl/nibble_handshake_link_core.sv @@
// Host side of a 4-bit handshake link to a front panel. Each s_ beat is one
// sampled tick of the panel pins plus an optional send byte; each m_ beat is
// the pin drive and status after that tick. One beat is taken every cycle
// when m_ready stays high. An accepted beat is loaded into the input register;
// when it advances, the result register is loaded from the combinational link
// state update and drives the m_ ports.
// Receive takes priority over send when both are pending in idle.
module nibble_handshake_link_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_panel_has_data_n,
    input  logic       s_panel_can_take_n,
    input  logic       s_confirm_n,
    input  logic [3:0] s_nibble_in,
    input  logic       s_tx_valid,
    input  logic [7:0] s_tx_byte,
    input  logic       s_tx_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_select_n,
    output logic       m_direction_pin,
    output logic       m_half_pin,
    output logic [3:0] m_nibble_out,
    output logic       m_drive_enable,
    output logic       m_rx_valid,
    output logic [7:0] m_rx_byte,
    output logic       m_tx_accept,
    output logic       m_busy_res
);
    import nhl_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t step_res;
    logic    advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.panel_has_data_n <= s_panel_has_data_n;
            in_item_reg.panel_can_take_n <= s_panel_can_take_n;
            in_item_reg.confirm_n        <= s_confirm_n;
            in_item_reg.nibble_in        <= s_nibble_in;
            in_item_reg.tx_valid         <= s_tx_valid;
            in_item_reg.tx_byte          <= s_tx_byte;
            in_item_reg.tx_last          <= s_tx_last;
        end
        if (advance)
            out_res_reg <= step_res;
    end

    nhl_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .res     (step_res)
    );

    assign m_valid         = out_valid_reg;
    assign m_select_n      = out_res_reg.select_n;
    assign m_direction_pin = out_res_reg.direction_pin;
    assign m_half_pin      = out_res_reg.half_pin;
    assign m_nibble_out    = out_res_reg.nibble_out;
    assign m_drive_enable  = out_res_reg.drive_enable;
    assign m_rx_valid      = out_res_reg.rx_valid;
    assign m_rx_byte       = out_res_reg.rx_byte;
    assign m_tx_accept     = out_res_reg.tx_accept;
    assign m_busy_res      = out_res_reg.busy_res;

endmodule

@@ rtl/nhl_fsm.sv @@
module nhl_fsm (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  nhl_pkg::item_t   item,
    output nhl_pkg::result_t res
);
    import nhl_pkg::*;

    `include "nibble_handshake_link_core_defines.svh"

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [3:0]         low_half_reg, low_half_next;
    logic [7:0]         send_hold_reg, send_hold_next;
    logic               send_more_reg, send_more_next;
    logic               in_rx;

    always_comb begin
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        low_half_next  = low_half_reg;
        send_hold_next = send_hold_reg;
        send_more_next = send_more_reg;
        res            = '0;

        unique case (phase_reg)
            PH_RX_LO: begin
                if (!item.confirm_n) begin
                    low_half_next = item.nibble_in;
                    phase_next    = PH_RX_LOREL;
                end
            end
            PH_RX_LOREL: if (item.confirm_n) phase_next = PH_RX_HI;
            PH_RX_HI: begin
                if (!item.confirm_n) begin
                    res.rx_valid = 1'b1;
                    res.rx_byte  = {item.nibble_in, low_half_reg};
                    phase_next   = PH_RX_HIREL;
                end
            end
            PH_RX_HIREL: begin
                // keep receiving while the panel still has data
                if (item.confirm_n)
                    phase_next = item.panel_has_data_n ? PH_IDLE : PH_RX_LO;
            end
            PH_TX_READY: if (!item.panel_can_take_n) phase_next = PH_TX_LO;
            PH_TX_LO:    if (!item.confirm_n) phase_next = PH_TX_LOREL;
            PH_TX_LOREL: if (item.confirm_n) phase_next = PH_TX_HI;
            PH_TX_HI:    if (!item.confirm_n) phase_next = PH_TX_HIREL;
            PH_TX_HIREL: begin
                if (item.confirm_n)
                    phase_next = send_more_reg ? PH_TX_NEXT : PH_IDLE;
            end
            PH_TX_NEXT: begin
                if (item.tx_valid) begin
                    send_hold_next = item.tx_byte;
                    send_more_next = !item.tx_last;
                    res.tx_accept  = 1'b1;
                    phase_next     = PH_TX_READY;
                end
            end
            default: begin
                // idle, and any unused code
                phase_next = PH_IDLE;
                if (!item.panel_has_data_n) begin
                    mode_next  = MODE_READ;
                    phase_next = PH_RX_LO;
                end else if (item.tx_valid) begin
                    send_hold_next = item.tx_byte;
                    send_more_next = !item.tx_last;
                    res.tx_accept  = 1'b1;
                    mode_next      = MODE_WRITE;
                    phase_next     = PH_TX_READY;
                end
            end
        endcase

        // pins shown after the update
        res.busy_res = (phase_next != PH_IDLE);
        res.select_n = !(phase_next == PH_RX_LO || phase_next == PH_RX_HI ||
                         phase_next == PH_TX_LO || phase_next == PH_TX_HI);
        res.half_pin = !(phase_next == PH_RX_LO || phase_next == PH_RX_LOREL ||
                         phase_next == PH_TX_READY || phase_next == PH_TX_LO ||
                         phase_next == PH_TX_LOREL);
        in_rx = (phase_next >= PH_RX_LO) && (phase_next <= PH_RX_HIREL);
        res.drive_enable  = (mode_next == MODE_WRITE) && !in_rx;
        res.direction_pin = res.drive_enable;
        if (res.drive_enable)
            res.nibble_out = res.half_pin ? send_hold_next[7:4] : send_hold_next[3:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            mode_reg      <= MODE_NONE;
            low_half_reg  <= '0;
            send_hold_reg <= '0;
            send_more_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            low_half_reg  <= low_half_next;
            send_hold_reg <= send_hold_next;
            send_more_reg <= send_more_next;
        end
    end

    `NHL_ASSERT_IMP(a_rx_only_from_hi, aclk, aresetn, step_en && res.rx_valid, phase_reg == PH_RX_HI)
    `NHL_ASSERT_IMP(a_take_when_free, aclk, aresetn, step_en && res.tx_accept, phase_reg == PH_IDLE || phase_reg == PH_TX_NEXT)
    `NHL_ASSERT_NXT(a_take_holds_byte, aclk, aresetn, step_en && res.tx_accept, send_hold_reg == $past(item.tx_byte))
    `NHL_ASSERT_IMP(a_no_drive_on_rx, aclk, aresetn, step_en && res.rx_valid, !res.drive_enable)

endmodule
